// File: hw/rtl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg: shared types and constants for the fixed-point ALU
// Operation codes, status codes and the width constants used by the units.
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int FracBitsDefault  = 8;
  localparam int WordWidthDefault = 32;
  localparam int OpWidth          = 4;
  localparam int StatusWidth      = 2;
  localparam int FieldWidth       = 32;

  typedef enum logic [OpWidth-1:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
    OP_GT  = 4'd4, OP_LT  = 4'd5, OP_GE  = 4'd6, OP_LE  = 4'd7,
    OP_EQ  = 4'd8, OP_NE  = 4'd9, OP_INC = 4'd10, OP_DEC = 4'd11,
    OP_MIN = 4'd12, OP_MAX = 4'd13, OP_TO_INT = 4'd14, OP_FROM_INT = 4'd15
  } op_t;

  typedef enum logic [StatusWidth-1:0] {
    ST_OK   = 2'd0,
    ST_OVF  = 2'd1,
    ST_DIV0 = 2'd2
  } status_t;

endpackage

// File: hw/rtl/fixed_point_alu.sv
// ----------------------------------------------------------------------------
// fixed_point_alu: pipelined signed fixed-point arithmetic unit
// Add, sub, mul, div, compares, inc/dec, min/max and integer conversions on
// raw words with FRAC_BITS fractional bits; saturating, mul and div round half away.
// ----------------------------------------------------------------------------
// channel | ports                                        | direction
// input   | in_valid in_stall in_req_type in_operand_a/b  | into block
// result  | out_valid out_stall out_result_value           | out of block
//         | out_compare_true out_status                    |
//
// One item may enter every cycle while in_stall is low; the pipeline depth is
// set by the bit-per-stage divider pipeline that every item travels through.
// Reset clears all stage valid bits; payload registers are not reset.
// A stall at the output freezes the whole pipe; in_stall is out_stall while
// the final stage holds a result, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module fixed_point_alu #(
  parameter int FRAC_BITS  = fpa_pkg::FracBitsDefault,
  parameter int WORD_WIDTH = fpa_pkg::WordWidthDefault
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [fpa_pkg::OpWidth-1:0]      in_req_type,
  input  logic signed [fpa_pkg::FieldWidth-1:0] in_operand_a,
  input  logic signed [fpa_pkg::FieldWidth-1:0] in_operand_b,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [fpa_pkg::FieldWidth-1:0] out_result_value,
  output logic                             out_compare_true,
  output logic [fpa_pkg::StatusWidth-1:0]  out_status
);

  localparam int W   = WORD_WIDTH;
  localparam int FW  = fpa_pkg::FieldWidth;
  localparam int NW  = W + FRAC_BITS;   // divider numerator width
  localparam int PW  = 2 * W;           // product width
  localparam int LAT = NW;              // stages from stage 1 to the end

  typedef struct packed {
    logic [fpa_pkg::OpWidth-1:0]     op;
    logic                            neg;
    logic [W-1:0]                    res;
    logic                            cmp;
    logic [fpa_pkg::StatusWidth-1:0] st;
    logic [W:0]                      dmag;  // divisor magnitude, for rounding
  } info_t;

  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // ---- stage 0: take the low W bits of the operands, form sign and magnitude
  logic [W-1:0] a_w, b_w;
  logic         an, bn;
  logic [W-1:0] am, bm;
  assign a_w = in_operand_a[W-1:0] & {W{1'b1}};
  assign b_w = in_operand_b[W-1:0];
  assign an  = a_w[W-1];
  assign bn  = b_w[W-1];
  assign am  = an ? (~a_w + 1'b1) : a_w;
  assign bm  = bn ? (~b_w + 1'b1) : b_w;

  logic [W-1:0] max_pos, min_neg;
  assign max_pos = {1'b0, {(W-1){1'b1}}};
  assign min_neg = {1'b1, {(W-1){1'b0}}};

  // simple ops and stage-1 record
  info_t s1_nxt;
  logic signed [W-1:0] sa, sb;
  logic [W-1:0] sum, dif;
  logic lt, gt;
  logic [NW-1:0] fromi;
  always_comb begin
    sa  = signed'(a_w);
    sb  = signed'(b_w);
    sum = a_w + b_w;
    dif = a_w - b_w;
    lt  = sa < sb;
    gt  = sb < sa;
    fromi = {{FRAC_BITS{1'b0}}, am} << FRAC_BITS;
    s1_nxt = '0;
    s1_nxt.op   = in_req_type;
    s1_nxt.neg  = an ^ bn;
    s1_nxt.dmag = {1'b0, bm};
    s1_nxt.st   = fpa_pkg::ST_OK;
    case (in_req_type)
      fpa_pkg::OP_ADD: begin
        s1_nxt.res = sum;
        if (an == bn && sum[W-1] != an) begin
          s1_nxt.st = fpa_pkg::ST_OVF; s1_nxt.res = an ? min_neg : max_pos;
        end
      end
      fpa_pkg::OP_SUB: begin
        s1_nxt.res = dif;
        if (an != bn && dif[W-1] != an) begin
          s1_nxt.st = fpa_pkg::ST_OVF; s1_nxt.res = an ? min_neg : max_pos;
        end
      end
      fpa_pkg::OP_GT: s1_nxt.cmp = gt;
      fpa_pkg::OP_LT: s1_nxt.cmp = lt;
      fpa_pkg::OP_GE: s1_nxt.cmp = !lt;
      fpa_pkg::OP_LE: s1_nxt.cmp = !gt;
      fpa_pkg::OP_EQ: s1_nxt.cmp = a_w == b_w;
      fpa_pkg::OP_NE: s1_nxt.cmp = a_w != b_w;
      fpa_pkg::OP_INC: begin
        if (a_w == max_pos) begin
          s1_nxt.st = fpa_pkg::ST_OVF; s1_nxt.res = max_pos;
        end else s1_nxt.res = a_w + 1'b1;
      end
      fpa_pkg::OP_DEC: begin
        if (a_w == min_neg) begin
          s1_nxt.st = fpa_pkg::ST_OVF; s1_nxt.res = min_neg;
        end else s1_nxt.res = a_w - 1'b1;
      end
      fpa_pkg::OP_MIN: s1_nxt.res = lt ? a_w : b_w;
      fpa_pkg::OP_MAX: s1_nxt.res = gt ? a_w : b_w;
      fpa_pkg::OP_TO_INT: s1_nxt.res = W'(sa >>> FRAC_BITS);
      fpa_pkg::OP_FROM_INT: begin
        s1_nxt.neg = an;
        if (fromi > {{FRAC_BITS{1'b0}}, (an ? min_neg : max_pos)}) begin
          s1_nxt.st = fpa_pkg::ST_OVF; s1_nxt.res = an ? min_neg : max_pos;
        end else s1_nxt.res = an ? W'(~fromi + 1'b1) : fromi[W-1:0];
      end
      fpa_pkg::OP_DIV: begin
        if (bm == '0) s1_nxt.st = fpa_pkg::ST_DIV0;
      end
      default: ;
    endcase
  end

  // ---- record pipeline (stage 1 .. LAT) with valid bits
  info_t inf_r [LAT+1];
  logic  vld_r [LAT+1];
  always_comb begin
    inf_r[0] = s1_nxt;
    vld_r[0] = in_valid;
  end
  for (genvar s = 0; s < LAT; s++) begin : g_pipe
    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[s+1] <= 1'b0;
      else if (adv) vld_r[s+1] <= vld_r[s];
    end
    always_ff @(posedge clk) begin
      if (adv) inf_r[s+1] <= inf_r[s];
    end
  end

  // ---- multiplier: register operands, multiply, register product
  logic [W-1:0] ma_r, mb_r;
  logic [PW-1:0] prod_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      ma_r   <= am;
      mb_r   <= bm;
      prod_r <= ma_r * mb_r;
    end
  end
  // product travels alongside the record to the end
  logic [PW-1:0] pd_r [LAT-1];
  always_comb pd_r[0] = prod_r;
  for (genvar s = 0; s < LAT-2; s++) begin : g_pd
    always_ff @(posedge clk) if (adv) pd_r[s+1] <= pd_r[s];
  end

  // ---- divider
  logic [NW-1:0] quo;
  logic [W:0]    rem;
  fpa_div #(.NW(NW), .DW(W)) u_div (
    .clk (clk),
    .adv (adv),
    .num ({{FRAC_BITS{1'b0}}, am} << FRAC_BITS),
    .den ((bm == '0) ? {{(W-1){1'b0}}, 1'b1} : bm),
    .quo (quo),
    .rem (rem)
  );

  // ---- final: round, saturate and pack, into the output register
  info_t        fin;
  logic [PW:0]  mr;
  logic [NW:0]  qr;
  logic [PW:0]  mag;
  logic [W:0]   lim;
  logic [W-1:0] res_o;
  logic [fpa_pkg::StatusWidth-1:0] st_o;
  always_comb begin
    fin = inf_r[LAT];
    mr  = ({1'b0, pd_r[LAT-2]} + ((PW+1)'(1) << FRAC_BITS >> 1)) >> FRAC_BITS;
    if (FRAC_BITS == 0) mr = {1'b0, pd_r[LAT-2]};
    qr  = {1'b0, quo} + (NW+1)'(({rem, 1'b0} >= {1'b0, fin.dmag}) ? 1 : 0);
    lim = fin.neg ? {1'b0, min_neg} : {1'b0, max_pos};
    mag = (fin.op == fpa_pkg::OP_MUL) ? mr : (PW+1)'(qr);
    res_o = fin.res;
    st_o  = fin.st;
    if ((fin.op == fpa_pkg::OP_MUL) ||
        (fin.op == fpa_pkg::OP_DIV && fin.st != fpa_pkg::ST_DIV0)) begin
      if (mag > (PW+1)'(lim)) begin
        st_o  = fpa_pkg::ST_OVF;
        res_o = lim[W-1:0];
      end else res_o = fin.neg ? W'(~mag + 1'b1) : mag[W-1:0];
    end
  end

  logic          ov_r;
  logic [FW-1:0] rv_r;
  logic          cmp_r;
  logic [fpa_pkg::StatusWidth-1:0] st_r;
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (adv) ov_r <= vld_r[LAT];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      rv_r  <= FW'(res_o);
      cmp_r <= fin.cmp;
      st_r  <= st_o;
    end
  end

  assign out_valid        = ov_r;
  assign out_result_value = rv_r;
  assign out_compare_true = cmp_r;
  assign out_status       = st_r;

  // ---- checks
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_value))
    else $error("result changed under stall");
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output stall");
  a_cmp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_compare_true |-> out_result_value == '0 && out_status == '0)
    else $error("compare result carries value");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("bad status code");

endmodule

// File: hw/rtl/fpa_div.sv
// ----------------------------------------------------------------------------
// fpa_div: pipelined restoring divider
// Unsigned magnitude divide, one quotient bit per stage, with advance enable.
// Gives quotient and remainder of (num / den) where num has NW bits.
// ----------------------------------------------------------------------------
module fpa_div #(
  parameter int NW = 40,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          adv,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo,
  output logic [DW:0]   rem
);

  // per-stage partial remainder, shifting numerator/quotient and divisor
  logic [DW:0]   rem_r [NW+1];
  logic [NW-1:0] nq_r  [NW+1];
  logic [DW-1:0] den_r [NW+1];

  always_comb begin
    rem_r[0] = '0;
    nq_r[0]  = num;
    den_r[0] = den;
  end

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [DW+1:0] trial;
    logic [DW+1:0] shifted;
    always_comb begin
      shifted = {rem_r[s], nq_r[s][NW-1]};
      trial   = shifted - {2'b00, den_r[s]};
    end
    // one quotient bit per stage; remainder stays below the divisor
    always_ff @(posedge clk) begin
      if (adv) begin
        den_r[s+1] <= den_r[s];
        if (!trial[DW+1]) begin
          rem_r[s+1] <= trial[DW:0];
          nq_r[s+1]  <= {nq_r[s][NW-2:0], 1'b1};
        end else begin
          rem_r[s+1] <= shifted[DW:0];
          nq_r[s+1]  <= {nq_r[s][NW-2:0], 1'b0};
        end
      end
    end
  end

  assign quo = nq_r[NW];
  assign rem = rem_r[NW];

endmodule
